@@ hdl/fhhd_pkg.sv @@
// shared types and constants of the flow rate heavy hitter detector
package fhhd_pkg;

    localparam int unsigned DIV_W     = 64;
    localparam int unsigned DIV_CNT_W = 6;

    // register indexes on the configuration port
    localparam logic [1:0] REG_RATE_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_REPORTS_PER_DONE = 2'd1;
    localparam logic [1:0] REG_UPSTREAM_ADDRESS = 2'd2;
    localparam logic [1:0] REG_REPLY_PORT       = 2'd3;

    localparam logic [31:0] RATE_THRESHOLD_RST   = 32'd10;
    localparam logic [15:0] REPORTS_PER_DONE_RST = 16'd2;
    localparam logic [31:0] UPSTREAM_ADDRESS_RST = 32'h0a01_0100;
    localparam logic [15:0] REPLY_PORT_RST       = 16'h1234;

    // message header length codes and kinds
    localparam logic [15:0] HH_LEN_CODE   = 16'd32;
    localparam logic [15:0] DONE_LEN_CODE = 16'd16;
    localparam logic [63:0] HH_KIND       = 64'd1;
    localparam logic [63:0] DONE_KIND     = 64'd0;

    localparam logic [2:0] HH_WORDS   = 3'd5;
    localparam logic [2:0] DONE_WORDS = 3'd3;

    typedef struct packed {
        logic [63:0] flow_addresses;
        logic [63:0] flow_ports;
        logic        start_flag;
        logic        fin_flag;
        logic [63:0] report_time;
        logic [15:0] packet_length;
        logic [31:0] switch_address;
        logic [63:0] nic_time;
    } t_in_word;

    typedef struct packed {
        logic [63:0] message_word;
        logic        end_of_message;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

@@ hdl/fhhd_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module fhhd_div
    import fhhd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       trial;

    // the shared subtract and compare
    always_comb begin
        rem_shift = {r_rem, r_quo[DIV_W-1]};
        trial     = rem_shift - {1'b0, r_den};
        if (!trial[DIV_W]) begin
            n_rem = trial[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = rem_shift[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

@@ hdl/flow_rate_heavy_hitter_detector_unit.sv @@
// top level of the flow rate heavy hitter detector
// per report: accept, table read (RD), rate check (CALC), the bit-serial divider
//   (DIV) unless a start report or zero elapsed time, update (UPD), words (OUT); MODW
//   and MODR come before RD when the table depth is not a power of two
//   (reciprocal multiply reduces the port); one report at a time, input stalls until
//   the last word is loaded (or the update, if none), longer while the output stalls
// reset: synchronous, active low; then a pass clearing every table entry stalls input
module flow_rate_heavy_hitter_detector_unit
    import fhhd_pkg::*;
#(
    parameter int FLOW_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // report words in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    // message words out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int  IDX_W = (FLOW_TABLE_DEPTH > 1) ? $clog2(FLOW_TABLE_DEPTH) : 1;
    localparam bit  POW2  = ((FLOW_TABLE_DEPTH & (FLOW_TABLE_DEPTH - 1)) == 0);
    // ceil(2^32 / depth), exact quotient for any 16-bit port
    localparam logic [31:0] MOD_RECIP =
        32'(((64'd1 << 32) + 64'(FLOW_TABLE_DEPTH) - 64'd1) / 64'(FLOW_TABLE_DEPTH));

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MODW  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_MODR  = 4'd8;

    logic [3:0]       r_state, n_state;

    // configuration registers
    logic [31:0]      r_rate_threshold;
    logic [15:0]      r_reports_per_done;
    logic [31:0]      r_upstream_address;
    logic [15:0]      r_reply_port;
    logic             cfg_wr;

    // per-report and global state
    t_in_word         r_in;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_hh;
    logic             r_done_msg;
    logic [2:0]       r_pos;
    logic [15:0]      r_counter;
    logic             r_first_seen;
    logic [63:0]      r_first_nic;

    // port reduction for a depth that is not a power of two
    logic [15:0]      mod_dport;
    logic [15:0]      r_mod_quo;
    logic [15:0]      mod_back;
    logic [15:0]      mod_rem;

    // flow table memories
    logic [63:0]      r_start_mem [FLOW_TABLE_DEPTH];
    logic [63:0]      r_count_mem [FLOW_TABLE_DEPTH];
    logic [63:0]      r_rd_start;
    logic [63:0]      r_rd_count;
    logic             start_we;
    logic             count_we;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      start_wdata;
    logic [63:0]      count_wdata;

    // rate path
    logic [63:0]      count_new;
    logic [63:0]      base_time;
    logic [63:0]      elapsed;
    logic             need_div;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    // counter update and output sequencing
    logic [15:0]      counter_inc;
    logic             done_now;
    logic [3:0]       total_words;
    logic             in_accept;
    logic             out_load;
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        cur_word;
    logic [2:0]       done_pos;
    logic             pos_last;

    //----------------------------------------------------------------------
    // configuration port, pready always high
    //----------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_threshold   <= RATE_THRESHOLD_RST;
            r_reports_per_done <= REPORTS_PER_DONE_RST;
            r_upstream_address <= UPSTREAM_ADDRESS_RST;
            r_reply_port       <= REPLY_PORT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RATE_THRESHOLD:   r_rate_threshold   <= pwdata;
                REG_REPORTS_PER_DONE: r_reports_per_done <= pwdata[15:0];
                REG_UPSTREAM_ADDRESS: r_upstream_address <= pwdata;
                REG_REPLY_PORT:       r_reply_port       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RATE_THRESHOLD:   prdata = r_rate_threshold;
            REG_REPORTS_PER_DONE: prdata = {16'd0, r_reports_per_done};
            REG_UPSTREAM_ADDRESS: prdata = r_upstream_address;
            REG_REPLY_PORT:       prdata = {16'd0, r_reply_port};
            default:              prdata = '0;
        endcase
    end

    //----------------------------------------------------------------------
    // flow index reduction: quotient by reciprocal multiply, then remainder
    //----------------------------------------------------------------------
    assign mod_dport = r_in.flow_ports[47:32];
    assign mod_back  = 16'({17'd0, r_mod_quo} * 33'(FLOW_TABLE_DEPTH));
    assign mod_rem   = mod_dport - mod_back;

    //----------------------------------------------------------------------
    // shared divider: rate = bits / elapsed
    //----------------------------------------------------------------------
    assign in_accept = i_in_valid & ~o_in_stall;

    // start report restarts the count and the start time
    assign count_new = (r_in.start_flag ? 64'd0 : r_rd_count) + 64'(r_in.packet_length);
    assign base_time = r_in.start_flag ? r_in.report_time : r_rd_start;
    assign elapsed   = r_in.report_time - base_time;
    // start report has zero rate, zero elapsed time saturates (always above)
    assign need_div  = ~r_in.start_flag & (elapsed != 64'd0);

    always_comb begin
        div_req = '0;
        if (r_state == S_CALC && need_div) begin
            div_req.start    = 1'b1;
            div_req.dividend = {count_new[60:0], 3'b000};
            div_req.divisor  = elapsed;
        end
    end

    fhhd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    //----------------------------------------------------------------------
    // flow table: one write port and one registered read port per memory
    //----------------------------------------------------------------------
    assign start_we    = (r_state == S_CLEAR) | ((r_state == S_CALC) & r_in.start_flag);
    assign count_we    = (r_state == S_CLEAR) | (r_state == S_CALC);
    assign wr_addr     = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign start_wdata = (r_state == S_CLEAR) ? 64'd0 : r_in.report_time;
    // fin clears the count after the rate check
    assign count_wdata = ((r_state == S_CLEAR) | r_in.fin_flag) ? 64'd0 : count_new;

    always_ff @(posedge i_clk) begin
        if (start_we) begin
            r_start_mem[wr_addr] <= start_wdata;
        end
        r_rd_start <= r_start_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (count_we) begin
            r_count_mem[wr_addr] <= count_wdata;
        end
        r_rd_count <= r_count_mem[r_idx];
    end

    //----------------------------------------------------------------------
    // report counter and done decision
    //----------------------------------------------------------------------
    assign counter_inc = r_counter + 16'd1;
    assign done_now    = (counter_inc >= r_reports_per_done);
    assign total_words = (r_hh ? 4'(HH_WORDS) : 4'd0) + (done_now ? 4'(DONE_WORDS) : 4'd0);

    //----------------------------------------------------------------------
    // message word selection: heavy hitter words first, then done words
    //----------------------------------------------------------------------
    assign done_pos = r_hh ? (r_pos - HH_WORDS) : r_pos;
    assign pos_last = r_done_msg ? (done_pos == DONE_WORDS - 3'd1)
                                 : (r_pos == HH_WORDS - 3'd1);

    always_comb begin
        cur_word = '0;
        if (r_hh && (r_pos < HH_WORDS)) begin
            case (r_pos)
                3'd0:    cur_word.message_word = {r_in.switch_address, r_reply_port,
                                                  HH_LEN_CODE};
                3'd1:    cur_word.message_word = HH_KIND;
                3'd2:    cur_word.message_word = r_in.flow_addresses;
                3'd3:    cur_word.message_word = r_in.flow_ports;
                default: cur_word.message_word = r_in.nic_time;
            endcase
            cur_word.end_of_message = (r_pos == HH_WORDS - 3'd1);
        end else begin
            case (done_pos)
                3'd0:    cur_word.message_word = {r_upstream_address, r_reply_port,
                                                  DONE_LEN_CODE};
                3'd1:    cur_word.message_word = DONE_KIND;
                default: cur_word.message_word = r_first_nic;
            endcase
            cur_word.end_of_message = (done_pos == DONE_WORDS - 3'd1);
        end
        cur_word.last = pos_last;
    end

    // output register parts the sequencer from the downstream stall
    assign out_load = (r_state == S_OUT) & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= cur_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_in_stall  = (r_state != S_IDLE);

    //----------------------------------------------------------------------
    // sequencer
    //----------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_W'(FLOW_TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = POW2 ? S_RD : S_MODW;
                end
            end
            S_MODW: n_state = S_MODR;
            S_MODR: n_state = S_RD;
            S_RD:   n_state = S_CALC;
            S_CALC: n_state = need_div ? S_DIV : S_UPD;
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:  n_state = (total_words == 4'd0) ? S_IDLE : S_OUT;
            S_OUT: begin
                if (out_load && pos_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_counter    <= '0;
            r_first_seen <= 1'b0;
            r_first_nic  <= '0;
            r_hh         <= 1'b0;
            r_done_msg   <= 1'b0;
            r_pos        <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr_addr <= r_clr_addr + 1'b1;
                S_CALC: begin
                    // start report never fires, zero elapsed always fires
                    r_hh <= ~r_in.start_flag & (elapsed == 64'd0);
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_hh <= (div_rsp.quotient > {32'd0, r_rate_threshold});
                    end
                end
                S_UPD: begin
                    if (!r_first_seen) begin
                        r_first_nic  <= r_in.nic_time;
                        r_first_seen <= 1'b1;
                    end
                    r_counter  <= done_now ? 16'd0 : counter_inc;
                    r_done_msg <= done_now;
                    r_pos      <= '0;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_pos <= r_pos + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // report payload and flow index
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_accept) begin
            r_in <= i_in_word;
            if (POW2) begin
                r_idx <= i_in_word.flow_ports[32 +: IDX_W];
            end
        end else if (r_state == S_MODW) begin
            r_mod_quo <= 16'(({32'd0, mod_dport} * {16'd0, MOD_RECIP}) >> 32);
        end else if (r_state == S_MODR) begin
            r_idx <= mod_rem[IDX_W-1:0];
        end
    end

endmodule

@@ hdl/fhhd_checker.sv @@
// port-level checker for the flow rate heavy hitter detector and its bind
module fhhd_checker
    import fhhd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   o_out_word
);

    // reset starts the table clearing pass, so no report is taken next
    a_reset_stalls: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one report at a time: the cycle after an accept the input stalls
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second report taken while busy");

    // last word of a report is always the final word of a message
    a_last_is_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> o_out_word.end_of_message)
        else $error("last word without end of message");

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled word changed");

endmodule

bind flow_rate_heavy_hitter_detector_unit fhhd_checker u_fhhd_checker (.*);
